>>> rtl/vec3_normalize_top_macros.svh
// assertion macros for the vec3_normalize checker
// used by vn_checker.sv; needs clk and arst_n in scope
`ifndef VEC3_NORMALIZE_TOP_MACROS_SVH
`define VEC3_NORMALIZE_TOP_MACROS_SVH
// same-cycle implication
`define VN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define VN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/vn_pkg.sv
// shared types and constants for the vec3_normalize pipeline
// no dependencies
`timescale 1ns / 1ps
package vn_pkg;
	localparam int COMP_W        = 32;
	localparam int SQ_W          = 2 * COMP_W;
	localparam int ROOT_W        = SQ_W / 2;
	localparam int REM_W         = ROOT_W + 2;
	localparam int OUT_FRAC_BITS = 30;
	localparam int Q_W           = OUT_FRAC_BITS + 1;
	localparam int LEN_W         = 33;
	localparam int S_DATA_W      = 3 * COMP_W;
	localparam int M_DATA_W      = ((3 * COMP_W + LEN_W + 7) / 8) * 8;

	typedef logic [2:0][COMP_W-1:0] vec_t;

	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0][COMP_W-1:0] mag;
	} side_t;
endpackage

>>> rtl/vn_square.sv
// magnitude, squaring and sum of squares: three pipeline stages
// depends on vn_pkg
`timescale 1ns / 1ps
module vn_square (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  vn_pkg::vec_t            in_vec,
	output logic                    out_valid,
	output logic [vn_pkg::SQ_W-1:0] out_sum,
	output vn_pkg::side_t           out_side
);
	import vn_pkg::*;

	logic                       valid_s1, valid_s2, valid_s3;
	side_t                      side_s1, side_s2, side_s3;
	logic [2:0][SQ_W-1:0]       sq_s2;
	logic [SQ_W-1:0]            sum_s3;
	side_t                      side_d;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side_d.neg[i] = in_vec[i][COMP_W-1];
			// most negative value maps to 2^31, which still fits unsigned
			side_d.mag[i] = in_vec[i][COMP_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= SQ_W'(side_s1.mag[i]) * SQ_W'(side_s1.mag[i]);
			end
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	assign out_valid = valid_s3;
	assign out_sum   = sum_s3;
	assign out_side  = side_s3;
endmodule

>>> rtl/vn_sqrt.sv
// floored integer square root, one root bit per pipeline stage
// depends on vn_pkg
`timescale 1ns / 1ps
module vn_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [vn_pkg::SQ_W-1:0]   in_sum,
	input  vn_pkg::side_t             in_side,
	output logic                      out_valid,
	output logic [vn_pkg::ROOT_W-1:0] out_root,
	output vn_pkg::side_t             out_side
);
	import vn_pkg::*;

	logic              valid_s [0:ROOT_W];
	logic [SQ_W-1:0]   num_s   [0:ROOT_W];
	logic [REM_W-1:0]  rem_s   [0:ROOT_W];
	logic [ROOT_W-1:0] root_s  [0:ROOT_W];
	side_t             side_s  [0:ROOT_W];

	assign valid_s[0] = in_valid;
	assign num_s[0]   = in_sum;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W+1:0] shifted, trial, diff;
		logic             ge;

		always_comb begin
			// bring down the next two bits of the radicand
			shifted = {rem_s[k], num_s[k][SQ_W-1 -: 2]};
			trial   = {2'b00, root_s[k], 2'b01};
			diff    = shifted - trial;
			ge      = (shifted >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1]  <= {num_s[k][SQ_W-3:0], 2'b00};
				rem_s[k+1]  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[ROOT_W];
	assign out_root  = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];
endmodule

>>> rtl/vn_div.sv
// three-lane restoring divider, one quotient bit per pipeline stage
// depends on vn_pkg
`timescale 1ns / 1ps
module vn_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [vn_pkg::ROOT_W-1:0] in_len,
	input  vn_pkg::side_t             in_side,
	output logic                      out_valid,
	output logic [2:0][vn_pkg::Q_W-1:0] out_quo,
	output logic [2:0]                out_neg,
	output logic [vn_pkg::ROOT_W-1:0] out_len
);
	import vn_pkg::*;

	logic                     valid_s [0:Q_W];
	logic [ROOT_W-1:0]        len_s   [0:Q_W];
	logic [2:0]               neg_s   [0:Q_W];
	logic [2:0][COMP_W-1:0]   rem_s   [0:Q_W];
	logic [2:0][Q_W-1:0]      quo_s   [0:Q_W];
	logic [2:0]               lsb_s   [0:Q_W];

	always_comb begin
		valid_s[0] = in_valid;
		len_s[0]   = in_len;
		neg_s[0]   = in_side.neg;
		quo_s[0]   = '0;
		for (int i = 0; i < 3; i++) begin
			// dividend is mag << OUT_FRAC_BITS; top part is mag >> 1, below len
			rem_s[0][i] = {1'b0, in_side.mag[i][COMP_W-1:1]};
			lsb_s[0][i] = in_side.mag[i][0];
		end
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		logic [2:0][COMP_W:0]   trial;
		logic [2:0][COMP_W:0]   diff;
		logic [2:0]             ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				trial[i] = {rem_s[j][i], lsb_s[j][i]};
				diff[i]  = trial[i] - {1'b0, len_s[j]};
				ge[i]    = (trial[i] >= {1'b0, len_s[j]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (en) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[j+1] <= len_s[j];
				neg_s[j+1] <= neg_s[j];
				lsb_s[j+1] <= 3'b000;
				for (int i = 0; i < 3; i++) begin
					rem_s[j+1][i] <= ge[i] ? diff[i][COMP_W-1:0] : trial[i][COMP_W-1:0];
					quo_s[j+1][i] <= {quo_s[j][i][Q_W-2:0], ge[i]};
				end
			end
		end
	end

	assign out_valid = valid_s[Q_W];
	assign out_quo   = quo_s[Q_W];
	assign out_neg   = neg_s[Q_W];
	assign out_len   = len_s[Q_W];
endmodule

>>> rtl/vec3_normalize_top.sv
// vec3_normalize: unit vector and length of a signed Q16.16 3-vector
// depends on vn_pkg, vn_square, vn_sqrt, vn_div
//
// slave side takes one vector word per handshake: x, y, z in tdata
// master side gives x_unit, y_unit, z_unit (signed Q1.30) and the length
// (unsigned Q16.16) in tdata, and the zero-vector flag in tuser
// a zero vector gives zero units, zero length and the flag set
// the pipeline runs through squares and sum, then the square root (one root
// bit per stage), then the three dividers (one quotient bit per stage) and
// 1 output register
// throughput is one vector per cycle while the receiver takes words
// when the receiver stalls with a word waiting the whole pipeline holds,
// s_tready drops and nothing is lost or repeated
// results leave in input order; no state is kept between vectors
// reset clears all valid bits, so the pipeline comes up empty
`timescale 1ns / 1ps
module vec3_normalize_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// x_in [31:0], y_in [63:32], z_in [95:64]
	input  logic [vn_pkg::S_DATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// x_unit [31:0], y_unit [63:32], z_unit [95:64], length [128:96], zero pad
	output logic [vn_pkg::M_DATA_W-1:0] m_tdata,
	// zero_vector [0]
	output logic                        m_tuser
);
	import vn_pkg::*;

	logic                   en;
	logic                   sq_valid, rt_valid, dv_valid;
	logic [SQ_W-1:0]        sq_sum;
	side_t                  sq_side, rt_side;
	logic [ROOT_W-1:0]      rt_root, dv_len;
	logic [2:0][Q_W-1:0]    dv_quo;
	logic [2:0]             dv_neg;
	logic                   valid_q;
	logic [M_DATA_W-1:0]    data_q;
	logic                   zero_q;
	logic [M_DATA_W-1:0]    data_d;
	logic                   zero_d;

	assign en       = !valid_q || m_tready;
	assign s_tready = en;

	vn_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_vec    (vec_t'(s_tdata)),
		.out_valid (sq_valid),
		.out_sum   (sq_sum),
		.out_side  (sq_side)
	);

	vn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_sum    (sq_sum),
		.in_side   (sq_side),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_side  (rt_side)
	);

	vn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rt_valid),
		.in_len    (rt_root),
		.in_side   (rt_side),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_neg   (dv_neg),
		.out_len   (dv_len)
	);

	always_comb begin
		logic [COMP_W-1:0] u;
		data_d = '0;
		zero_d = (dv_len == '0);
		for (int i = 0; i < 3; i++) begin
			u = {{(COMP_W-Q_W){1'b0}}, dv_quo[i]};
			if (dv_neg[i]) begin
				u = ~u + 1'b1;
			end
			if (zero_d) begin
				u = '0;
			end
			data_d[i*COMP_W +: COMP_W] = u;
		end
		data_d[3*COMP_W +: LEN_W] = {{(LEN_W-ROOT_W){1'b0}}, dv_len};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= data_d;
			zero_q <= zero_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = zero_q;
endmodule

>>> rtl/vn_checker.sv
// port-level checks for vec3_normalize_top, bound to the top level
// depends on vn_pkg and vec3_normalize_top_macros.svh
`timescale 1ns / 1ps
`include "vec3_normalize_top_macros.svh"
module vn_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [vn_pkg::M_DATA_W-1:0] m_tdata,
	input logic                        m_tuser
);
	import vn_pkg::*;

	logic signed [COMP_W-1:0] x_unit;
	logic [LEN_W-1:0]         len_f;
	logic                     unit_ok;
	logic [M_DATA_W:0]        out_word;

	assign x_unit   = m_tdata[COMP_W-1:0];
	assign len_f    = m_tdata[3*COMP_W +: LEN_W];
	assign unit_ok  = (x_unit <= (1 <<< OUT_FRAC_BITS)) &&
		(x_unit >= -(1 <<< OUT_FRAC_BITS));
	assign out_word = {m_tuser, m_tdata};

	// flagged word carries all-zero payload
	`VN_ASSERT_NOW(a_zero_payload, m_tvalid && m_tuser, m_tdata == '0, "zero vector word not zero")
	// unflagged word has a non-zero length
	`VN_ASSERT_NOW(a_len_nonzero, m_tvalid && !m_tuser, len_f != '0, "length zero without flag")
	// x unit component stays within plus or minus one
	`VN_ASSERT_NOW(a_unit_range, m_tvalid, unit_ok, "x_unit out of range")
	// input side stalls exactly when an output word is held
	`VN_ASSERT_NOW(a_ready_link, 1'b1, s_tready == (!m_tvalid || m_tready), "ready not tied")
	// held word stays put
	`VN_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_word), "word changed")
endmodule

bind vec3_normalize_top vn_checker u_vn_checker (.*);
